// ===== rtl/core/nbd_pkg.sv =====
// Shared types, constants and constant tables for the nearest boundary direction unit.
// Depends on nothing; every module of the unit imports it.
package nbd_pkg;

  localparam int NBR         = 124;  // neighbours in the 5x5x5 window, centre skipped
  localparam int CENTER_POS  = 62;
  localparam int WIN_SIDE    = 5;
  localparam int WIN_PLANE   = 25;
  localparam int WIN_HALF    = 2;
  localparam int SHELLS      = 9;    // distinct squared distances 1,2,3,4,5,6,8,9,12
  localparam int SHELL_W     = 4;
  localparam int GROUPS      = 16;
  localparam int GROUP_SIZE  = 8;
  localparam int PCNT_W      = 4;
  localparam int TCNT_W      = 7;
  localparam int CNT_W       = 5;    // at most 24 neighbours in one shell
  localparam int UNIT_W      = 17;   // signed Q1.15 component, +-32768
  localparam int SUM_W       = 21;
  localparam int SCALE_SHIFT = 7;    // 127 = 2^7 - 1
  localparam int Q_SHIFT     = 15;
  localparam int MAG_W       = 12;
  localparam int RECIP_W     = 19;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = MAG_W + RECIP_W;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  localparam logic [7:0] MAX_LEVEL      = 8'hFF;
  localparam logic [7:0] SURFACE_RESET  = 8'hFF;

  typedef struct packed {
    logic [7:0]  center_value;
    logic [63:0] differs_low;
    logic [59:0] differs_high;
  } win_t;

  typedef struct packed {
    logic signed [7:0] dir_x;
    logic signed [7:0] dir_y;
    logic signed [7:0] dir_z;
    logic [7:0]        edge_level;
  } dir_t;

  typedef struct packed {
    logic [NBR-1:0] mask;
    logic [7:0]     edge_level;
    logic           flip;
  } shell_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic [CNT_W-1:0]        count;
    logic [7:0]              edge_level;
    logic                    flip;
  } sum_t;

  // Unit component magnitude, indexed by squared distance and absolute offset.
  localparam int UNIT_Q15 [13][3] = '{
    '{0, 0, 0},
    '{0, 32768, 0},
    '{0, 23170, 0},
    '{0, 18919, 0},
    '{0, 0, 32768},
    '{0, 14654, 29309},
    '{0, 13377, 26755},
    '{0, 0, 0},
    '{0, 0, 23170},
    '{0, 10923, 21845},
    '{0, 0, 0},
    '{0, 0, 0},
    '{0, 0, 18919}
  };

  function automatic int win_pos(int b);
    return (b < CENTER_POS) ? b : b + 1;
  endfunction

  function automatic int offset(int b, int axis);
    int p;
    p = win_pos(b);
    case (axis)
      AXIS_X:  return (p % WIN_SIDE) - WIN_HALF;
      AXIS_Y:  return ((p / WIN_SIDE) % WIN_SIDE) - WIN_HALF;
      default: return (p / WIN_PLANE) - WIN_HALF;
    endcase
  endfunction

  function automatic int dist2(int b);
    int x, y, z;
    x = offset(b, AXIS_X);
    y = offset(b, AXIS_Y);
    z = offset(b, AXIS_Z);
    return x * x + y * y + z * z;
  endfunction

  // Shell number in order of growing distance.
  function automatic int shell_of(int b);
    case (dist2(b))
      1:       return 0;
      2:       return 1;
      3:       return 2;
      4:       return 3;
      5:       return 4;
      6:       return 5;
      8:       return 6;
      9:       return 7;
      default: return 8;
    endcase
  endfunction

  function automatic logic signed [UNIT_W-1:0] unit_comp(int b, int axis);
    int o, a, m;
    o = offset(b, axis);
    a = (o < 0) ? -o : o;
    m = UNIT_Q15[dist2(b)][a];
    return UNIT_W'((o < 0) ? -m : m);
  endfunction

  // ceil(2^18 / c); exact floor division for magnitudes below 2^12.
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] c);
    case (c)
      5'd1:    return RECIP_W'(262144);
      5'd2:    return RECIP_W'(131072);
      5'd3:    return RECIP_W'(87382);
      5'd4:    return RECIP_W'(65536);
      5'd5:    return RECIP_W'(52429);
      5'd6:    return RECIP_W'(43691);
      5'd7:    return RECIP_W'(37450);
      5'd8:    return RECIP_W'(32768);
      5'd9:    return RECIP_W'(29128);
      5'd10:   return RECIP_W'(26215);
      5'd11:   return RECIP_W'(23832);
      5'd12:   return RECIP_W'(21846);
      5'd13:   return RECIP_W'(20165);
      5'd14:   return RECIP_W'(18725);
      5'd15:   return RECIP_W'(17477);
      5'd16:   return RECIP_W'(16384);
      5'd17:   return RECIP_W'(15421);
      5'd18:   return RECIP_W'(14564);
      5'd19:   return RECIP_W'(13798);
      5'd20:   return RECIP_W'(13108);
      5'd21:   return RECIP_W'(12484);
      5'd22:   return RECIP_W'(11916);
      5'd23:   return RECIP_W'(11398);
      5'd24:   return RECIP_W'(10923);
      default: return '0;
    endcase
  endfunction

endpackage

// ===== rtl/core/nbd_shell_sel.sv =====
// First pipeline stage: pick the nearest occupied distance shell and keep only its bits.
// Depends on nbd_pkg.
module nbd_shell_sel (
  input  logic           clk,
  input  logic           rst,
  input  logic           win_valid,
  output logic           win_stall,
  input  nbd_pkg::win_t  win,
  input  logic [7:0]     marker,
  output logic           sel_valid,
  input  logic           sel_stall,
  output nbd_pkg::shell_t sel
);
  import nbd_pkg::*;

  logic [NBR-1:0]     mask;
  logic [SHELLS-1:0]  any;
  logic [SHELL_W-1:0] sel_shell;
  logic [NBR-1:0]     sel_mask;
  logic               adv;

  assign mask = {win.differs_high, win.differs_low};

  always_comb begin
    any = '0;
    for (int b = 0; b < NBR; b++) begin
      any[shell_of(b)] = any[shell_of(b)] | mask[b];
    end
    sel_shell = '0;
    for (int s = SHELLS - 1; s >= 0; s--) begin
      if (any[s]) begin
        sel_shell = SHELL_W'(s);
      end
    end
    for (int b = 0; b < NBR; b++) begin
      sel_mask[b] = mask[b] && (SHELL_W'(shell_of(b)) == sel_shell);
    end
  end

  assign adv       = !sel_valid || !sel_stall;
  assign win_stall = !adv;

  // Drop empty windows here: they give no word.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (adv) begin
      sel_valid <= win_valid && (|any);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sel.mask       <= sel_mask;
      sel.edge_level <= MAX_LEVEL - win.center_value;
      sel.flip       <= (win.center_value == marker);
    end
  end

endmodule

// ===== rtl/core/nbd_accum.sv =====
// Second and third pipeline stages: sum unit vectors and count bits of the chosen shell.
// Depends on nbd_pkg; group partial sums first, then the total.
module nbd_accum (
  input  logic            clk,
  input  logic            rst,
  input  logic            sel_valid,
  output logic            sel_stall,
  input  nbd_pkg::shell_t sel,
  output logic            sum_valid,
  input  logic            sum_stall,
  output nbd_pkg::sum_t   sum
);
  import nbd_pkg::*;

  logic signed [SUM_W-1:0]  px [GROUPS];
  logic signed [SUM_W-1:0]  py [GROUPS];
  logic signed [SUM_W-1:0]  pz [GROUPS];
  logic [PCNT_W-1:0]        pc [GROUPS];
  logic signed [SUM_W-1:0]  px_next [GROUPS];
  logic signed [SUM_W-1:0]  py_next [GROUPS];
  logic signed [SUM_W-1:0]  pz_next [GROUPS];
  logic [PCNT_W-1:0]        pc_next [GROUPS];
  logic [7:0]               p_edge;
  logic                     p_flip;
  logic                     p_valid;
  logic signed [SUM_W-1:0]  tx, ty, tz;
  logic [TCNT_W-1:0]        tc;
  logic                     adv_p, adv_t;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      px_next[g] = '0;
      py_next[g] = '0;
      pz_next[g] = '0;
      pc_next[g] = '0;
    end
    for (int b = 0; b < NBR; b++) begin
      if (sel.mask[b]) begin
        px_next[b / GROUP_SIZE] = px_next[b / GROUP_SIZE] + SUM_W'(unit_comp(b, AXIS_X));
        py_next[b / GROUP_SIZE] = py_next[b / GROUP_SIZE] + SUM_W'(unit_comp(b, AXIS_Y));
        pz_next[b / GROUP_SIZE] = pz_next[b / GROUP_SIZE] + SUM_W'(unit_comp(b, AXIS_Z));
        pc_next[b / GROUP_SIZE] = pc_next[b / GROUP_SIZE] + PCNT_W'(1);
      end
    end
  end

  always_comb begin
    tx = '0;
    ty = '0;
    tz = '0;
    tc = '0;
    for (int g = 0; g < GROUPS; g++) begin
      tx = tx + px[g];
      ty = ty + py[g];
      tz = tz + pz[g];
      tc = tc + TCNT_W'(pc[g]);
    end
  end

  assign adv_t     = !sum_valid || !sum_stall;
  assign adv_p     = !p_valid || adv_t;
  assign sel_stall = !adv_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      if (adv_p) begin
        p_valid <= sel_valid;
      end
      if (adv_t) begin
        sum_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_p) begin
      px     <= px_next;
      py     <= py_next;
      pz     <= pz_next;
      pc     <= pc_next;
      p_edge <= sel.edge_level;
      p_flip <= sel.flip;
    end
    if (adv_t) begin
      sum.sx         <= tx;
      sum.sy         <= ty;
      sum.sz         <= tz;
      sum.count      <= tc[CNT_W-1:0];
      sum.edge_level <= p_edge;
      sum.flip       <= p_flip;
    end
  end

endmodule

// ===== rtl/core/nbd_scale.sv =====
// Stages four to six: scale sums by 127/32768, divide by the count, apply the sign.
// Depends on nbd_pkg; division is a reciprocal multiply from a constant table.
module nbd_scale (
  input  logic          clk,
  input  logic          rst,
  input  logic          sum_valid,
  output logic          sum_stall,
  input  nbd_pkg::sum_t sum,
  output logic          dir_valid,
  input  logic          dir_stall,
  output nbd_pkg::dir_t dir_word
);
  import nbd_pkg::*;

  logic signed [SUM_W-1:0]       s    [3];
  logic [SUM_W-1:0]              absv [3];
  logic [SUM_W+SCALE_SHIFT-1:0]  t    [3];
  logic [MAG_W-1:0]              mag  [3];
  logic                          neg_m [3];
  logic [RECIP_W-1:0]            rcp;
  logic [7:0]                    edge_m;
  logic                          m_valid;
  logic [PROD_W-1:0]             prod [3];
  logic                          neg_p [3];
  logic [7:0]                    edge_p;
  logic                          p_valid;
  logic [7:0]                    q    [3];
  logic [7:0]                    res  [3];
  logic                          adv_m, adv_p, adv_o;

  assign s[AXIS_X] = sum.sx;
  assign s[AXIS_Y] = sum.sy;
  assign s[AXIS_Z] = sum.sz;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absv[i] = s[i][SUM_W-1] ? SUM_W'(-s[i]) : SUM_W'(s[i]);
      t[i]    = {absv[i], SCALE_SHIFT'(0)} - {SCALE_SHIFT'(0), absv[i]};
      q[i]    = prod[i][RECIP_SHIFT +: 8];
      res[i]  = neg_p[i] ? 8'(-q[i]) : q[i];
    end
  end

  assign adv_o     = !dir_valid || !dir_stall;
  assign adv_p     = !p_valid || adv_o;
  assign adv_m     = !m_valid || adv_p;
  assign sum_stall = !adv_m;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid   <= 1'b0;
      p_valid   <= 1'b0;
      dir_valid <= 1'b0;
    end else begin
      if (adv_m) begin
        m_valid <= sum_valid;
      end
      if (adv_p) begin
        p_valid <= m_valid;
      end
      if (adv_o) begin
        dir_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_m) begin
      for (int i = 0; i < 3; i++) begin
        mag[i]   <= t[i][Q_SHIFT +: MAG_W];
        neg_m[i] <= s[i][SUM_W-1] ^ sum.flip;
      end
      rcp    <= recip(sum.count);
      edge_m <= sum.edge_level;
    end
    if (adv_p) begin
      for (int i = 0; i < 3; i++) begin
        prod[i]  <= PROD_W'(mag[i]) * PROD_W'(rcp);
        neg_p[i] <= neg_m[i];
      end
      edge_p <= edge_m;
    end
    if (adv_o) begin
      dir_word.dir_x      <= res[AXIS_X];
      dir_word.dir_y      <= res[AXIS_Y];
      dir_word.dir_z      <= res[AXIS_Z];
      dir_word.edge_level <= edge_p;
    end
  end

endmodule

// ===== rtl/core/nearest_boundary_direction_unit.sv =====
// Throughput: one window word per cycle while win_stall is low; a stalled output only backs up stages that hold words.
// Reset (rst, synchronous): drop all words in flight, set surface_marker to 255.
// Empty masks are dropped in the first stage and produce no direction word.
// Depends on nbd_pkg, nbd_shell_sel, nbd_accum and nbd_scale.
module nearest_boundary_direction_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          win_valid,
  output logic          win_stall,
  input  nbd_pkg::win_t win,
  output logic          dir_valid,
  input  logic          dir_stall,
  output nbd_pkg::dir_t dir_word,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_data
);
  import nbd_pkg::*;

  // Surface marker register; the user must write it only while the pipe is empty, the block does not enforce this.
  logic [7:0] surface_marker;

  logic   sel_valid, sel_stall;
  shell_t sel;
  logic   sum_valid, sum_stall;
  sum_t   sum;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_marker <= SURFACE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      surface_marker <= cfg_data;
    end
  end

  // Stage 1: find the nearest occupied shell, mask off the rest.
  nbd_shell_sel u_sel (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win_stall (win_stall),
    .win       (win),
    .marker    (surface_marker),
    .sel_valid (sel_valid),
    .sel_stall (sel_stall),
    .sel       (sel)
  );

  // Stages 2-3: per-group partial sums, then totals and count.
  nbd_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .sel_valid (sel_valid),
    .sel_stall (sel_stall),
    .sel       (sel),
    .sum_valid (sum_valid),
    .sum_stall (sum_stall),
    .sum       (sum)
  );

  // Stages 4-6: scale by 127, divide by count, negate for surface voxels.
  nbd_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .sum_valid (sum_valid),
    .sum_stall (sum_stall),
    .sum       (sum),
    .dir_valid (dir_valid),
    .dir_stall (dir_stall),
    .dir_word  (dir_word)
  );

  // An empty output stage lets every stage advance, so the input never stalls then.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (rst)
    !dir_valid |-> !win_stall)
    else $error("window input stalled while output stage is empty");

  // A mean of unit vectors times 127 never reaches -128.
  a_dir_in_range: assert property (@(posedge clk) disable iff (rst)
    dir_valid |-> (dir_word.dir_x != 8'sh80) && (dir_word.dir_y != 8'sh80)
                  && (dir_word.dir_z != 8'sh80))
    else $error("direction component out of range");

  // Reset flushes the pipe.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !dir_valid && !win_stall)
    else $error("words survived reset");

endmodule

// ===== tb/nearest_boundary_direction_unit_tb.sv =====
// Testbench for nearest_boundary_direction_unit. It predicts each direction word from the window
// word and the surface marker, and checks every word that leaves the block in order.
// Depends on nbd_pkg and the unit's RTL.
`timescale 1ns / 1ps

module nearest_boundary_direction_unit_tb;
  import nbd_pkg::win_t;
  import nbd_pkg::dir_t;

  localparam int NUM_NBRS     = 124;
  localparam int DRAIN_CYCLES = 12;  // drain time after the last expected word, covers dropped empty masks
  localparam int MAX_PRINTS   = 40;

  logic       clk;
  logic       rst       = 1'b1;
  logic       win_valid = 1'b0;
  logic       win_stall;
  win_t       win       = '0;
  logic       dir_valid;
  logic       dir_stall = 1'b0;
  dir_t       dir_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  // Expected direction words, oldest first, and our own copy of the surface marker.
  dir_t       expected_dirs[$];
  logic [7:0] surface_model = 8'hFF;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int stall_left;
  int mismatches;
  int windows_sent;
  int empty_sent;
  int words_checked;
  int reversed_words;
  int marker_writes;

  nearest_boundary_direction_unit dut (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win_stall (win_stall),
    .win       (win),
    .dir_valid (dir_valid),
    .dir_stall (dir_stall),
    .dir_word  (dir_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case a word never arrives or a handshake hangs.
  initial begin
    #400_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // Window geometry and direction prediction
  // ---------------------------------------------------------------------------------------------

  // Offsets of mask bit b; the raster skips the centre at window position 62.
  function automatic void nbr_offset(input int b, output int x, output int y, output int z);
    int p;
    p = (b < 62) ? b : b + 1;
    x = p % 5 - 2;
    y = (p / 5) % 5 - 2;
    z = p / 25 - 2;
  endfunction

  function automatic int nbr_d2(input int b);
    int x, y, z;
    nbr_offset(b, x, y, z);
    return x * x + y * y + z * z;
  endfunction

  // Squared distance of the i-th shell, nearest first.
  function automatic int shell_by_rank(input int i);
    case (i)
      0:       return 1;
      1:       return 2;
      2:       return 3;
      3:       return 4;
      4:       return 5;
      5:       return 6;
      6:       return 8;
      7:       return 9;
      default: return 12;
    endcase
  endfunction

  // Unit component o / sqrt(d2) in Q1.15, magnitude rounded to nearest, sign of the offset.
  function automatic int unit_q15(input int o, input int d2);
    int mag;
    mag = (o == 0) ? 0 : $rtoi((o < 0 ? -o : o) * 32768.0 / $sqrt($itor(d2)) + 0.5);
    return (o < 0) ? -mag : mag;
  endfunction

  // Work out the direction word for one window; return 0 when the mask is empty.
  function automatic bit predict_direction(input win_t w, input logic [7:0] marker,
                                           output dir_t d);
    logic [123:0] m;
    int     b, a, near, cnt, d2;
    int     off [3];
    int     sum [3];
    int     comp [3];
    longint num, den;
    m    = {w.differs_high, w.differs_low};
    near = 1000;
    cnt  = 0;
    d    = '0;
    for (a = 0; a < 3; a++) sum[a] = 0;
    for (b = 0; b < NUM_NBRS; b++) begin
      if (m[b]) begin
        nbr_offset(b, off[0], off[1], off[2]);
        d2 = nbr_d2(b);
        // A nearer shell restarts the sum; farther shells are dropped.
        if (d2 < near) begin
          near = d2;
          cnt  = 0;
          for (a = 0; a < 3; a++) sum[a] = 0;
        end
        if (d2 == near) begin
          for (a = 0; a < 3; a++) sum[a] += unit_q15(off[a], d2);
          cnt++;
        end
      end
    end
    if (cnt == 0) return 1'b0;
    for (a = 0; a < 3; a++) begin
      num = sum[a];
      num = num * 127;
      den = cnt;
      den = den * 32768;
      comp[a] = int'(num / den);  // truncates toward zero
      if (w.center_value == marker) comp[a] = -comp[a];
    end
    d.dir_x      = comp[0][7:0];
    d.dir_y      = comp[1][7:0];
    d.dir_z      = comp[2][7:0];
    d.edge_level = 8'hFF - w.center_value;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------------

  function automatic win_t make_window(input logic [7:0] centre, input logic [123:0] mask);
    win_t w;
    w.center_value = centre;
    w.differs_low  = mask[63:0];
    w.differs_high = mask[123:64];
    return w;
  endfunction

  // All neighbours whose squared distance lies in [lo_d2, hi_d2].
  function automatic logic [123:0] shell_bits(input int lo_d2, input int hi_d2);
    logic [123:0] m;
    int           b;
    m = '0;
    for (b = 0; b < NUM_NBRS; b++) m[b] = (nbr_d2(b) >= lo_d2) && (nbr_d2(b) <= hi_d2);
    return m;
  endfunction

  // Mask whose nearest marked shell is near_d2: random nonempty subset of that shell,
  // nothing nearer, and farther neighbours set with probability far_pct percent.
  function automatic logic [123:0] nearest_shell_mask(input int near_d2, input int far_pct);
    logic [123:0] m;
    int           b, d2;
    bit           hit;
    m   = '0;
    hit = 1'b0;
    for (b = 0; b < NUM_NBRS; b++) begin
      d2 = nbr_d2(b);
      if (d2 == near_d2) begin
        m[b] = 1'($urandom_range(0, 1));
        hit |= m[b];
      end else if (d2 > near_d2) begin
        m[b] = ($urandom_range(0, 99) < far_pct);
      end
    end
    while (!hit) begin
      b = $urandom_range(0, NUM_NBRS - 1);
      if (nbr_d2(b) == near_d2) begin
        m[b] = 1'b1;
        hit  = 1'b1;
      end
    end
    return m;
  endfunction

  // Favor the marker value so reversed directions come up often.
  function automatic logic [7:0] pick_centre();
    return ($urandom_range(0, 2) == 0) ? surface_model : 8'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("t=%0d ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Send one window word. Valid stays high after acceptance so the next call can go
  // back to back; a random gap drops it first.
  task automatic send_window(input logic [7:0] centre, input logic [123:0] mask);
    dir_t want;
    int   gap;
    gap = tx_idle ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      win_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    win_valid <= 1'b1;
    win       <= make_window(centre, mask);
    @(posedge clk);
    while (win_stall) @(posedge clk);
    windows_sent++;
    if (predict_direction(make_window(centre, mask), surface_model, want)) begin
      expected_dirs.push_back(want);
      if (centre == surface_model) reversed_words++;
    end else begin
      empty_sent++;
    end
  endtask

  // Hold the sender until every expected word is back, then let dropped windows clear.
  task automatic wait_until_idle();
    win_valid <= 1'b0;
    while (expected_dirs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Only call with the block idle.
  task automatic write_surface_marker(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid     <= 1'b0;
    surface_model = value;
    marker_writes++;
  endtask

  task automatic send_random_window();
    logic [123:0] m;
    int           kind;
    kind = $urandom_range(0, 9);
    if (kind < 8) begin
      m = nearest_shell_mask(shell_by_rank($urandom_range(0, 8)), $urandom_range(0, 100));
    end else if (kind == 8) begin
      m = 124'({$urandom, $urandom, $urandom, $urandom});
    end else begin
      // Lone random neighbour or an empty mask.
      m = '0;
      if ($urandom_range(0, 1)) m[$urandom_range(0, NUM_NBRS - 1)] = 1'b1;
    end
    send_window(pick_centre(), m);
  endtask

  // ---------------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------------

  // Corner cases with the marker at its reset value of 255.
  task automatic test_directed_windows();
    logic [123:0] m;
    int           i, b;
    send_window(8'h00, '0);
    send_window(8'hFF, '0);
    send_window(8'h00, '1);
    send_window(8'hFF, '1);
    // One lone neighbour per shell.
    for (i = 0; i < 9; i++) begin
      b = 0;
      while (nbr_d2(b) != shell_by_rank(i)) b++;
      m    = '0;
      m[b] = 1'b1;
      send_window(8'($urandom_range(0, 255)), m);
    end
    // Opposite corners and the two neighbours around the skipped centre.
    m = '0; m[0]   = 1'b1; send_window(8'hFF, m);
    m = '0; m[123] = 1'b1; send_window(8'h7F, m);
    m = '0; m[61]  = 1'b1; send_window(8'h80, m);
    m = '0; m[62]  = 1'b1; send_window(8'h01, m);
    // Full shell of 24 cancels to zero; 23 of 24 leaves a small residue.
    send_window(8'h55, shell_bits(5, 5) | shell_bits(8, 12));
    m = shell_bits(6, 12);
    b = 0;
    while (nbr_d2(b) != 6) b++;
    m[b] = 1'b0;
    send_window(8'hAA, m);
    m = '0; m[123:64] = '1; send_window(8'h80, m);
    m = '0; m[63:0]   = '1; send_window(8'hFE, m);
    // Lone +x neighbour in the nearest shell under everything farther: full-scale reversed.
    m = shell_bits(2, 12);
    m[62] = 1'b1;
    send_window(8'hFF, m);
    wait_until_idle();
  endtask

  // Walk the marker through its extremes and a few middle values.
  task automatic test_marker_settings();
    logic [7:0] setting;
    int         i, k;
    for (i = 0; i < 5; i++) begin
      case (i)
        0:       setting = 8'h00;
        1:       setting = 8'hFF;
        2:       setting = 8'h80;
        default: setting = 8'($urandom_range(1, 254));
      endcase
      write_surface_marker(setting);
      for (k = 0; k < 10; k++)
        send_window((k % 2 == 0) ? setting : 8'($urandom_range(0, 255)),
                    nearest_shell_mask(shell_by_rank($urandom_range(0, 8)),
                                       $urandom_range(0, 100)));
      wait_until_idle();
    end
  endtask

  // Bulk random traffic in chunks of 50 producing windows; each chunk draws its own idling,
  // and every fourth chunk drains and moves the marker.
  task automatic test_random_windows(input int n);
    int c, target;
    for (c = 0; c < n / 50; c++) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (c % 4 == 3) begin
        wait_until_idle();
        write_surface_marker(8'($urandom_range(0, 255)));
      end
      target = windows_sent - empty_sent + 50;
      while (windows_sent - empty_sent < target) send_random_window();
    end
    wait_until_idle();
  endtask

  // Full rate on both sides.
  task automatic test_back_to_back(input int n);
    int target;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    target  = windows_sent - empty_sent + n;
    while (windows_sent - empty_sent < target) send_random_window();
    wait_until_idle();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // ---------------------------------------------------------------------------------------------
  // Output side: stall at random and check each accepted direction word
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk) begin : dir_check
    dir_t want;
    if (rst) begin
      stall_left = 0;
      dir_stall  <= 1'b0;
    end else begin
      if (dir_valid && !dir_stall) begin
        if (expected_dirs.size() == 0) begin
          report_mismatch("direction word with none expected", int'(dir_word), -1);
        end else begin
          want = expected_dirs.pop_front();
          words_checked++;
          if (dir_word.dir_x !== want.dir_x)
            report_mismatch("dir_x", int'(dir_word.dir_x), int'(want.dir_x));
          if (dir_word.dir_y !== want.dir_y)
            report_mismatch("dir_y", int'(dir_word.dir_y), int'(want.dir_y));
          if (dir_word.dir_z !== want.dir_z)
            report_mismatch("dir_z", int'(dir_word.dir_z), int'(want.dir_z));
          if (dir_word.edge_level !== want.edge_level)
            report_mismatch("edge_level", int'(dir_word.edge_level), int'(want.edge_level));
        end
        stall_left = rx_idle ? $urandom_range(0, 3) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (rx_idle && !dir_valid && $urandom_range(0, 7) == 0) begin
        // Raise stall now and then before a word shows up.
        stall_left = $urandom_range(1, 3);
      end
      dir_stall <= (stall_left > 0);
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_windows();
    test_marker_settings();
    test_random_windows(950);
    test_back_to_back(150);
    $display("Sent %0d windows (%0d with no marked neighbour), checked %0d direction words,",
             windows_sent, empty_sent, words_checked);
    $display("%0d of them reversed, across %0d surface marker writes and idle/full-rate phases.",
             reversed_words, marker_writes);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
